FILE: design/dual_interval_timer_with_irq_defines.svh
// ----------------------------------------------------------------------------
// Dual interval timer assertion macros
// Shared concurrent check forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_INTERVAL_TIMER_WITH_IRQ_DEFINES_SVH
`define DUAL_INTERVAL_TIMER_WITH_IRQ_DEFINES_SVH

// same-cycle implication
`define DIT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dit: same-cycle check failed");

// next-cycle implication
`define DIT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dit: next-cycle check failed");

`endif

FILE: design/dit_pkg.sv
// ----------------------------------------------------------------------------
// Dual interval timer package
// Beat payload types, operation codes, register offsets and control bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dit_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] reg_index;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       underflow_a;
        logic       underflow_b;
    } result_t;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [3:0] REG_TA_LO = 4'd4;
    localparam logic [3:0] REG_TA_HI = 4'd5;
    localparam logic [3:0] REG_TB_LO = 4'd6;
    localparam logic [3:0] REG_TB_HI = 4'd7;
    localparam logic [3:0] REG_ICR   = 4'd13;
    localparam logic [3:0] REG_CRA   = 4'd14;
    localparam logic [3:0] REG_CRB   = 4'd15;

    // script action bits
    localparam logic [7:0] ACT_RUN  = 8'h01;
    localparam logic [7:0] ACT_LOAD = 8'h02;
    localparam logic [7:0] ACT_END  = 8'h04;
    localparam logic [7:0] ACT_UFL  = 8'h08;
    localparam logic [7:0] ACT_BUSY = 8'h0e;

    // control byte
    localparam logic [7:0] CTL_FORCE_LOAD  = 8'h10;
    localparam logic [7:0] CTL_CNT_MODE    = 8'h20;
    localparam logic [7:0] CTL_INMODE_MASK = 8'h60;
    localparam logic [7:0] CTL_INMODE_TA   = 8'h40;
    localparam logic [7:0] CTL_CLR_START   = 8'hfe;

    localparam logic [7:0] ICR_SRC_MASK = 8'h1f;

endpackage

FILE: design/dual_interval_timer_with_irq.sv
// ----------------------------------------------------------------------------
// Dual interval timer with interrupt
// Each beat is one clock tick, one register write or one register read. The
// block accepts one beat every clock cycle while the result side is not
// stalled and returns exactly one result beat per input beat: the beat is
// captured in an input register, the whole tick, write or read is evaluated by
// combinational logic against the timer state, and the result lands in an
// output register. The state update of a beat is registered together with its
// result, so back-to-back beats see each other's effects in order. The longest
// path is the timer A tick chained into two timer B evaluations in linked mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_interval_timer_with_irq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  dit_pkg::item_t item,
    output logic           result_valid,
    input  logic           result_ready,
    output dit_pkg::result_t result,
    input  logic           cfg_we,
    input  logic           cfg_wdata
);

    import dit_pkg::*;

`include "dual_interval_timer_with_irq_defines.svh"

    typedef struct packed {
        logic [15:0] cnt;
        logic [15:0] lat;
        logic [7:0]  ctl;
        logic [23:0] scr;
    } tmr_t;

    typedef struct packed {
        tmr_t t;
        logic stop;
        logic keep;
        logic act_ufl;
        logic act_load;
    } pre_t;

    typedef struct packed {
        tmr_t t;
        logic ufl;
    } cnt_t;

    typedef struct packed {
        tmr_t t;
        logic ufl;
        logic set_delay;
    } node_t;

    function automatic pre_t tmr_pre(tmr_t t);
        pre_t       r;
        logic [7:0] act;
        r          = '0;
        r.t        = t;
        act        = t.scr[7:0];
        if (t.scr != 24'h0)
        begin
            r.t.scr = {8'h00, t.scr[23:8]};
            if ((act & ACT_BUSY) == 8'h00)
            begin
                if ((act & ACT_RUN) != 8'h00)
                    r.keep = 1'b1;
                else
                    r.stop = 1'b1;
            end
            else
            begin
                r.act_ufl  = (act & ACT_UFL) != 8'h00;
                r.act_load = (act & ACT_LOAD) != 8'h00;
            end
        end
        return r;
    endfunction

    function automatic cnt_t tmr_count(tmr_t t, logic keep);
        cnt_t r;
        r.t   = t;
        r.ufl = 1'b0;
        if (t.ctl[0] || keep)
        begin
            if (t.cnt <= 16'd1)
            begin
                r.ufl   = 1'b1;
                r.t.scr = t.scr | {16'h0000, ACT_UFL};
                r.t.cnt = t.lat;
                if (t.ctl[3])
                    r.t.ctl = t.ctl & CTL_CLR_START;
            end
            else
            begin
                r.t.cnt = t.cnt - 16'd1;
            end
        end
        return r;
    endfunction

    // one tick with no nested B tick
    function automatic node_t tmr_leaf(tmr_t t, logic match);
        pre_t  p;
        cnt_t  c;
        node_t r;
        p           = tmr_pre(t);
        c           = tmr_count(p.t, p.keep);
        r.t         = p.t;
        r.ufl       = 1'b0;
        r.set_delay = 1'b0;
        if (p.act_ufl || p.act_load)
        begin
            r.set_delay = p.act_ufl & match;
            if (p.act_load)
                r.t.cnt = p.t.lat;
        end
        else if (!p.stop)
        begin
            r.t   = c.t;
            r.ufl = c.ufl;
        end
        return r;
    endfunction

    // timer B tick; a pending underflow action in linked mode clocks B once more
    function automatic node_t tmr_b_node(tmr_t t, logic match, logic linked);
        pre_t  p;
        cnt_t  c;
        node_t inner;
        node_t r;
        p           = tmr_pre(t);
        c           = tmr_count(p.t, p.keep);
        inner       = tmr_leaf(p.t, match);
        r.t         = p.t;
        r.ufl       = 1'b0;
        r.set_delay = 1'b0;
        if (p.act_ufl || p.act_load)
        begin
            r.set_delay = p.act_ufl & match;
            if (p.act_ufl && linked)
            begin
                r.t         = inner.t;
                r.ufl       = inner.ufl;
                r.set_delay = r.set_delay | inner.set_delay;
            end
            if (p.act_load)
                r.t.cnt = r.t.lat;
        end
        else if (!p.stop)
        begin
            r.t   = c.t;
            r.ufl = c.ufl;
        end
        return r;
    endfunction

    function automatic tmr_t ctl_write(tmr_t t, logic [7:0] v);
        tmr_t       r;
        logic [7:0] dm;
        r  = t;
        dm = t.ctl[0] ? ACT_RUN : 8'h00;
        if ((v & CTL_FORCE_LOAD) != 8'h00)
            r.scr = {ACT_LOAD, ACT_LOAD, dm};
        else if (t.ctl[0] != v[0])
            r.scr = {ACT_END, dm, dm};
        r.ctl = ((v & CTL_CNT_MODE) != 8'h00) ? (v & CTL_CLR_START) : v;
        return r;
    endfunction

    // pipeline control
    item_t   item_q_reg;
    logic    item_q_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    advance;

    // block state
    logic       icr_set_allowed_reg;
    tmr_t       tmr_a_reg;
    tmr_t       tmr_a_next;
    tmr_t       tmr_b_reg;
    tmr_t       tmr_b_next;
    logic [4:0] irq_mask_reg;
    logic [4:0] irq_mask_next;
    logic [7:0] irq_status_reg;
    logic [7:0] irq_status_next;
    logic [1:0] irq_delay_reg;
    logic [1:0] irq_delay_next;
    logic [7:0] plain_regs_reg [16];
    logic       plain_wr_en;

    // tick datapath
    logic [1:0] match_now;
    logic       b_linked;
    pre_t       pa;
    cnt_t       ca;
    node_t      bn_link;
    node_t      bn_free;
    tmr_t       a_tick;
    tmr_t       b_tick;
    logic       ufl_a_tick;
    logic       ufl_b_tick;
    logic       set_dly_tick;
    logic [7:0] icr_wr;
    logic [7:0] icr_src;

    assign advance      = item_q_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_q_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign match_now = irq_status_reg[1:0] & irq_mask_reg[1:0];
    assign b_linked  = (tmr_b_reg.ctl & CTL_INMODE_MASK) == CTL_INMODE_TA;
    assign pa        = tmr_pre(tmr_a_reg);
    assign ca        = tmr_count(pa.t, pa.keep);
    assign bn_link   = tmr_b_node(tmr_b_reg, match_now[1], 1'b1);
    assign bn_free   = tmr_b_node(tmr_b_reg, match_now[1], 1'b0);

    assign icr_wr  = {item_q_reg.write_data[7] & icr_set_allowed_reg,
                      item_q_reg.write_data[6:0]};
    assign icr_src = icr_wr & ICR_SRC_MASK;

    always_comb
    begin
        a_tick       = pa.t;
        ufl_a_tick   = 1'b0;
        set_dly_tick = 1'b0;
        b_tick       = tmr_b_reg;
        ufl_b_tick   = 1'b0;
        if (pa.act_ufl || pa.act_load)
        begin
            set_dly_tick = pa.act_ufl & match_now[0];
            if (pa.act_load)
                a_tick.cnt = pa.t.lat;
        end
        else if (!pa.stop)
        begin
            a_tick     = ca.t;
            ufl_a_tick = ca.ufl;
        end
        if (b_linked)
        begin
            if (pa.act_ufl)
            begin
                b_tick       = bn_link.t;
                ufl_b_tick   = bn_link.ufl;
                set_dly_tick = set_dly_tick | bn_link.set_delay;
            end
        end
        else
        begin
            b_tick       = bn_free.t;
            ufl_b_tick   = bn_free.ufl;
            set_dly_tick = set_dly_tick | bn_free.set_delay;
        end
    end

    always_comb
    begin
        tmr_a_next      = tmr_a_reg;
        tmr_b_next      = tmr_b_reg;
        irq_mask_next   = irq_mask_reg;
        irq_status_next = irq_status_reg;
        irq_delay_next  = irq_delay_reg;
        plain_wr_en     = 1'b0;
        result_next     = '0;
        unique case (item_q_reg.op)
            OP_TICK:
            begin
                if (irq_delay_reg != 2'd0)
                begin
                    irq_delay_next = irq_delay_reg - 2'd1;
                    if (irq_delay_reg == 2'd1 && match_now != 2'b00)
                        irq_status_next[7] = 1'b1;
                end
                tmr_a_next              = a_tick;
                tmr_b_next              = b_tick;
                irq_status_next[1:0]    = irq_status_reg[1:0] | {ufl_b_tick, ufl_a_tick};
                if (set_dly_tick)
                    irq_delay_next = 2'd1;
                if ((irq_status_next[1:0] & irq_mask_reg[1:0]) != 2'b00
                    && !irq_status_next[7])
                    irq_delay_next = 2'd1;
                result_next.underflow_a = ufl_a_tick;
                result_next.underflow_b = ufl_b_tick;
            end
            OP_WRITE:
            begin
                unique case (item_q_reg.reg_index)
                    REG_TA_LO: tmr_a_next.lat[7:0] = item_q_reg.write_data;
                    REG_TA_HI:
                    begin
                        tmr_a_next.lat[15:8] = item_q_reg.write_data;
                        if (!tmr_a_reg.ctl[0])
                            tmr_a_next.cnt = {item_q_reg.write_data, tmr_a_reg.lat[7:0]};
                    end
                    REG_TB_LO: tmr_b_next.lat[7:0] = item_q_reg.write_data;
                    REG_TB_HI:
                    begin
                        tmr_b_next.lat[15:8] = item_q_reg.write_data;
                        if (!tmr_b_reg.ctl[0])
                            tmr_b_next.cnt = {item_q_reg.write_data, tmr_b_reg.lat[7:0]};
                    end
                    REG_ICR:
                    begin
                        if (icr_wr[7])
                        begin
                            irq_mask_next = irq_mask_reg | icr_src[4:0];
                            if ((irq_status_reg[1:0] & irq_mask_next[1:0]) != 2'b00
                                && !irq_status_reg[7])
                                irq_delay_next = 2'd2;
                        end
                        else
                        begin
                            irq_mask_next = irq_mask_reg & ~icr_src[4:0];
                        end
                    end
                    REG_CRA: tmr_a_next = ctl_write(tmr_a_reg, item_q_reg.write_data);
                    REG_CRB: tmr_b_next = ctl_write(tmr_b_reg, item_q_reg.write_data);
                    default: plain_wr_en = 1'b1;
                endcase
            end
            OP_READ:
            begin
                unique case (item_q_reg.reg_index)
                    REG_TA_LO: result_next.read_data = tmr_a_reg.cnt[7:0];
                    REG_TA_HI: result_next.read_data = tmr_a_reg.cnt[15:8];
                    REG_TB_LO: result_next.read_data = tmr_b_reg.cnt[7:0];
                    REG_TB_HI: result_next.read_data = tmr_b_reg.cnt[15:8];
                    REG_ICR:
                    begin
                        result_next.read_data = irq_status_reg;
                        irq_status_next       = 8'h00;
                    end
                    REG_CRA:   result_next.read_data = tmr_a_reg.ctl;
                    REG_CRB:   result_next.read_data = tmr_b_reg.ctl;
                    default:   result_next.read_data = plain_regs_reg[item_q_reg.reg_index];
                endcase
            end
            default: ;
        endcase
        result_next.irq_line = irq_status_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_q_valid_reg    <= 1'b0;
            result_valid_reg    <= 1'b0;
            icr_set_allowed_reg <= 1'b1;
            tmr_a_reg           <= '0;
            tmr_b_reg           <= '0;
            irq_mask_reg        <= '0;
            irq_status_reg      <= '0;
            irq_delay_reg       <= '0;
            for (int i = 0; i < 16; i++)
                plain_regs_reg[i] <= 8'h00;
        end
        else
        begin
            if (cfg_we)
                icr_set_allowed_reg <= cfg_wdata;
            if (item_ready)
                item_q_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (advance)
            begin
                tmr_a_reg      <= tmr_a_next;
                tmr_b_reg      <= tmr_b_next;
                irq_mask_reg   <= irq_mask_next;
                irq_status_reg <= irq_status_next;
                irq_delay_reg  <= irq_delay_next;
                if (plain_wr_en)
                    plain_regs_reg[item_q_reg.reg_index] <= item_q_reg.write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_q_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    `DIT_ASSERT_NEXT(a_icr_read_clears, advance && item_q_reg.op == OP_READ && item_q_reg.reg_index == REG_ICR, irq_status_reg == 8'h00)
    `DIT_ASSERT_NEXT(a_ufl_only_on_tick, advance && item_q_reg.op != OP_TICK, !result_reg.underflow_a && !result_reg.underflow_b)
    `DIT_ASSERT_NEXT(a_irq_line_tracks, advance, result_reg.irq_line == irq_status_reg[7])
    `DIT_ASSERT_IMP(a_cnt_mode_a_stopped, tmr_a_reg.ctl[5], !tmr_a_reg.ctl[0])
    `DIT_ASSERT_IMP(a_delay_in_range, 1'b1, irq_delay_reg != 2'd3)

endmodule
